>>> sv/fpsc_pkg.sv
// Shared types and constants for the fixed-point sine/cosine evaluator.
package fpsc_pkg;

    typedef logic signed [31:0] t_angle;
    typedef logic signed [18:0] t_value;

    localparam logic [18:0] TWO_PI    = 19'd411775;
    localparam logic [18:0] PI        = 19'd205887;
    localparam logic [18:0] HALF_PI   = 19'd102944;

    // 2^31 mod 2*pi, and its complement, for the sign-offset correction
    localparam logic [18:0] OFFS      = 19'd77023;
    localparam logic [18:0] OFFS_COMP = 19'd334752;

    // fold limits on the reduced angle in [0, 2*pi)
    localparam logic [18:0] FOLD_LO   = 19'd308831;
    localparam logic [18:0] FOLD_ADD  = 19'd205888;

    localparam int unsigned RECIP_SHIFT = 50;
    localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'd411775;
    localparam logic [31:0] RECIP       = RECIP_FULL[31:0];

    localparam logic signed [14:0] C3 = 15'sd10923;
    localparam logic signed [10:0] C5 = 11'sd546;

endpackage

>>> sv/fpsc_if.sv
// Valid/ready channel interfaces for requests and results.
interface fpsc_in_if;
    logic            valid;
    logic            ready;
    logic            req_type;
    fpsc_pkg::t_angle angle;

    modport source (output valid, output req_type, output angle, input ready);
    modport sink   (input valid, input req_type, input angle, output ready);
endinterface

interface fpsc_out_if;
    logic            valid;
    logic            ready;
    fpsc_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> sv/fixed_point_sine_cosine.sv
// Pipelined Q16.16 sine/cosine evaluator, top level.
//
// Usage:
//   i_req carries one item per handshake: req_type (0 = sine, 1 = cosine) and
//   a signed Q16.16 angle. o_rsp returns one signed Q3.16 value per item, in
//   order. Both channels transfer when valid and ready are high at a clock edge.
//   Pipeline: twelve register stages. With no stall the result is valid on
//   o_rsp once the item has reached the last stage. Throughput: one item per
//   cycle unless stalled. The 32x32 reciprocal multiply of the range reduction
//   and the chain of Taylor-term multiplies each sit in their own stages, so no
//   stage chains more than one multiply or one add and select.
//   Reset (i_rst_n low at a clock edge) clears all stage valid bits; items in
//   flight are dropped.
//   Stall: when o_rsp.ready is low the last stage holds its item and each
//   earlier stage holds only if it is full and the next one holds, so empty
//   slots are filled and i_req.ready falls only once every stage holds an item.
module fixed_point_sine_cosine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fpsc_in_if.sink          i_req,
    fpsc_out_if.source       o_rsp
);

    localparam int unsigned STAGES = 12;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES:0]   w_en;

    always_comb begin
        w_en[STAGES] = o_rsp.ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_req.valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_req.ready = w_en[0];

    // stage 0: cosine offset, then bias the angle to unsigned
    logic [31:0] n_sum;
    logic [31:0] n_u;
    logic [31:0] r_u0;
    assign n_sum = unsigned'(i_req.angle)
                   + (i_req.req_type ? 32'(fpsc_pkg::HALF_PI) : 32'd0);
    assign n_u   = {~n_sum[31], n_sum[30:0]};

    // stage 1: quotient estimate by reciprocal
    logic [63:0] n_prod;
    logic [13:0] n_q;
    logic [13:0] r_q;
    logic [31:0] r_u1;
    assign n_prod = 64'(r_u0) * 64'(fpsc_pkg::RECIP);
    assign n_q    = n_prod[63:50];

    // stage 2: quotient times modulus
    logic [31:0] n_t;
    logic [31:0] r_t;
    logic [31:0] r_u2;
    assign n_t = 32'(r_q) * 32'(fpsc_pkg::TWO_PI);

    // stage 3: remainder estimate in [0, 2*TWO_PI)
    logic [31:0] n_dfull;
    logic [19:0] r_d;
    assign n_dfull = r_u2 - r_t;

    // stage 4: correct remainder into [0, TWO_PI)
    logic [18:0] n_r1;
    logic [18:0] r_r1;
    assign n_r1 = (r_d >= 20'(fpsc_pkg::TWO_PI)) ? 19'(r_d - 20'(fpsc_pkg::TWO_PI))
                                                 : r_d[18:0];

    // stage 5: remove the bias offset modulo TWO_PI
    logic [18:0] n_c;
    logic [18:0] r_c;
    assign n_c = (r_r1 >= fpsc_pkg::OFFS) ? r_r1 - fpsc_pkg::OFFS
                                          : r_r1 + fpsc_pkg::OFFS_COMP;

    // stage 6: map to [-pi, pi] and fold into [-pi/2, pi/2]
    logic signed [19:0] n_fold;
    logic signed [19:0] w_c20;
    logic signed [17:0] r_f6;
    assign w_c20 = signed'({1'b0, r_c});
    always_comb begin
        if (r_c <= fpsc_pkg::HALF_PI) begin
            n_fold = w_c20;
        end else if (r_c <= fpsc_pkg::PI) begin
            n_fold = signed'({1'b0, fpsc_pkg::PI}) - w_c20;
        end else if (r_c < fpsc_pkg::FOLD_LO) begin
            n_fold = signed'({1'b0, fpsc_pkg::FOLD_ADD}) - w_c20;
        end else begin
            n_fold = w_c20 - signed'({1'b0, fpsc_pkg::TWO_PI});
        end
    end

    // stage 7: x^2
    logic signed [35:0] n_p2;
    logic [17:0]        r_x2_7;
    logic signed [17:0] r_f7;
    assign n_p2 = r_f6 * r_f6;

    // stage 8: x^3
    logic signed [18:0] w_x2s7;
    logic signed [36:0] n_p3;
    logic signed [18:0] r_x3;
    logic [17:0]        r_x2_8;
    logic signed [17:0] r_f8;
    assign w_x2s7 = signed'({1'b0, r_x2_7});
    assign n_p3   = w_x2s7 * r_f7;

    // stage 9: x^5 and the cubic term
    logic signed [18:0] w_x2s8;
    logic signed [37:0] n_p5;
    logic signed [33:0] n_p3c;
    logic signed [20:0] r_x5;
    logic signed [16:0] r_t3;
    logic signed [17:0] r_f9;
    assign w_x2s8 = signed'({1'b0, r_x2_8});
    assign n_p5   = r_x3 * w_x2s8;
    assign n_p3c  = r_x3 * fpsc_pkg::C3;

    // stage 10: fifth-order term and partial sum
    logic signed [31:0] n_p5c;
    logic signed [18:0] n_a;
    logic signed [13:0] r_t5;
    logic signed [18:0] r_a;
    assign n_p5c = r_x5 * fpsc_pkg::C5;
    assign n_a   = 19'(r_f9) - 19'(r_t3);

    // stage 11: final sum
    logic signed [18:0] n_res;
    fpsc_pkg::t_value   r_res;
    assign n_res = r_a + 19'(r_t5);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_u0 <= n_u;
        end
        if (w_en[1]) begin
            r_q  <= n_q;
            r_u1 <= r_u0;
        end
        if (w_en[2]) begin
            r_t  <= n_t;
            r_u2 <= r_u1;
        end
        if (w_en[3]) begin
            r_d <= n_dfull[19:0];
        end
        if (w_en[4]) begin
            r_r1 <= n_r1;
        end
        if (w_en[5]) begin
            r_c <= n_c;
        end
        if (w_en[6]) begin
            r_f6 <= n_fold[17:0];
        end
        if (w_en[7]) begin
            r_x2_7 <= n_p2[33:16];
            r_f7   <= r_f6;
        end
        if (w_en[8]) begin
            r_x3   <= n_p3[34:16];
            r_x2_8 <= r_x2_7;
            r_f8   <= r_f7;
        end
        if (w_en[9]) begin
            r_x5 <= n_p5[36:16];
            r_t3 <= n_p3c[32:16];
            r_f9 <= r_f8;
        end
        if (w_en[10]) begin
            r_t5 <= n_p5c[29:16];
            r_a  <= n_a;
        end
        if (w_en[11]) begin
            r_res <= n_res;
        end
    end

    assign o_rsp.valid = r_vld[STAGES-1];
    assign o_rsp.value = r_res;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !w_en[6]) |=> (r_vld[5] && $stable(r_c)))
        else $error("stalled stage lost or changed its item");

    a_reduce_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_c < fpsc_pkg::TWO_PI))
        else $error("reduced angle out of range");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> ((r_f6 <= 18'sd102944) && (r_f6 >= -18'sd102944)))
        else $error("folded angle out of range");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((r_res <= 19'sd65832) && (r_res >= -19'sd65832)))
        else $error("result out of range");

endmodule
